FILE: rtl/sll_pkg.sv
package sll_pkg;

  // table geometry
  localparam int CAPACITY   = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 32;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int OUT_DATA_W = ((2 * CNT_W + 7) / 8) * 8;

  // link value meaning "no slot"
  localparam logic [CNT_W-1:0] NO_SLOT = CNT_W'(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_WR_VAL_NEW,
    DP_STEP,
    DP_MARK_LOC,
    DP_WR_LINK_NEW,
    DP_LINK_PRED_NEW,
    DP_UNLINK,
    DP_HEAD_LOC,
    DP_WALK_START,
    DP_FIX_LINK,
    DP_RD_LAST,
    DP_MOVE
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    resp;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            cur_end;
    logic            below;
    logic            equal;
    logic            link_hit;
    logic            loc_is_last;
    logic            head_is_last;
    logic            out_free;
  } dp_stat_t;

endpackage

FILE: rtl/sll_ram.sv
module sll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sll_dp.sv
module sll_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sll_pkg::dp_cmd_t              cmd,
  output sll_pkg::dp_stat_t             st,
  input  logic [sll_pkg::KEY_W-1:0]     in_tdata,
  input  logic [sll_pkg::OP_W-1:0]      in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sll_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [sll_pkg::ST_W-1:0]      out_tuser
);
  import sll_pkg::*;

  logic [OP_W-1:0]         op_r, op_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        p_r, p_nxt;
  logic [CNT_W-1:0]        c_r, c_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        loc_r, loc_nxt;
  logic [CNT_W-1:0]        nxt_r, nxt_nxt;
  logic [CNT_W-1:0]        slot_r, slot_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;
  logic [CNT_W-1:0]        out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;

  logic                    val_we;
  logic [IDX_W-1:0]        val_waddr;
  logic [KEY_W-1:0]        val_wdata;
  logic [KEY_W-1:0]        val_rd;
  logic                    link_we;
  logic [IDX_W-1:0]        link_waddr;
  logic [CNT_W-1:0]        link_wdata;
  logic [CNT_W-1:0]        link_rd;
  logic [IDX_W-1:0]        raddr;

  sll_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rd)
  );

  sll_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (link_rd)
  );

  // read port follows the walk pointer, except when fetching the top slot
  assign raddr = (cmd.op == DP_RD_LAST) ? count_r[IDX_W-1:0] : c_r[IDX_W-1:0];

  always_comb begin
    val_we    = 1'b0;
    val_waddr = loc_r[IDX_W-1:0];
    val_wdata = val_rd;
    link_we    = 1'b0;
    link_waddr = p_r[IDX_W-1:0];
    link_wdata = nxt_r;
    case (cmd.op)
      DP_WR_VAL_NEW: begin
        val_we    = 1'b1;
        val_waddr = count_r[IDX_W-1:0];
        val_wdata = key_r;
      end
      DP_WR_LINK_NEW: begin
        link_we    = 1'b1;
        link_waddr = count_r[IDX_W-1:0];
        link_wdata = (c_r < NO_SLOT) ? c_r : NO_SLOT;
      end
      DP_LINK_PRED_NEW: begin
        link_we    = (p_r != NO_SLOT);
        link_waddr = p_r[IDX_W-1:0];
        link_wdata = count_r;
      end
      DP_UNLINK: begin
        link_we    = (p_r != NO_SLOT);
        link_waddr = p_r[IDX_W-1:0];
        link_wdata = nxt_r;
      end
      DP_FIX_LINK: begin
        link_we    = 1'b1;
        link_waddr = c_r[IDX_W-1:0];
        link_wdata = loc_r;
      end
      DP_MOVE: begin
        val_we     = 1'b1;
        val_waddr  = loc_r[IDX_W-1:0];
        val_wdata  = val_rd;
        link_we    = 1'b1;
        link_waddr = loc_r[IDX_W-1:0];
        link_wdata = link_rd;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    op_nxt    = op_r;
    key_nxt   = key_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    p_nxt     = p_r;
    c_nxt     = c_r;
    n_nxt     = n_r;
    loc_nxt   = loc_r;
    nxt_nxt   = nxt_r;
    slot_nxt  = slot_r;
    case (cmd.op)
      DP_LOAD: begin
        op_nxt   = in_tuser;
        key_nxt  = in_tdata;
        p_nxt    = NO_SLOT;
        c_nxt    = head_r;
        n_nxt    = '0;
        slot_nxt = NO_SLOT;
      end
      DP_STEP: begin
        p_nxt = c_r;
        c_nxt = link_rd;
        n_nxt = n_r + CNT_W'(1);
      end
      DP_MARK_LOC: begin
        loc_nxt  = c_r;
        nxt_nxt  = link_rd;
        slot_nxt = c_r;
      end
      DP_LINK_PRED_NEW: begin
        if (p_r == NO_SLOT) begin
          head_nxt = count_r;
        end
        slot_nxt  = count_r;
        count_nxt = count_r + CNT_W'(1);
      end
      DP_UNLINK: begin
        if (p_r == NO_SLOT) begin
          head_nxt = nxt_r;
        end
        count_nxt = count_r - CNT_W'(1);
      end
      DP_HEAD_LOC: begin
        head_nxt = loc_r;
      end
      DP_WALK_START: begin
        c_nxt = head_r;
        n_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    if (cmd.resp) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.status;
      out_slot_nxt   = slot_r;
      out_count_nxt  = count_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NO_SLOT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    p_r          <= p_nxt;
    c_r          <= c_nxt;
    n_r          <= n_nxt;
    loc_r        <= loc_nxt;
    nxt_r        <= nxt_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    st.op           = op_r;
    st.full         = (count_r >= NO_SLOT);
    st.cur_end      = (c_r >= NO_SLOT) || (n_r >= NO_SLOT);
    st.below        = ($signed(val_rd) < key_r);
    st.equal        = (val_rd == key_r);
    st.link_hit     = (link_rd == count_r);
    st.loc_is_last  = (loc_r == count_r);
    st.head_is_last = (head_r == count_r);
    st.out_free     = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DATA_W'({out_count_r, out_slot_r});

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NO_SLOT)
    else $error("entry count above capacity");

  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == (head_r == NO_SLOT))
    else $error("head and count disagree on empty list");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.resp && cmd.status == ST_FULL) |-> (count_r == NO_SLOT))
    else $error("insert refused while table not full");
`endif

endmodule

FILE: rtl/sll_ctrl.sv
module sll_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  sll_pkg::dp_stat_t  st,
  output sll_pkg::dp_cmd_t   cmd
);
  import sll_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_I_CHK,
    S_I_RD,
    S_I_CMP,
    S_I_LINK,
    S_I_PRED,
    S_L_CHK,
    S_L_RD,
    S_L_CMP,
    S_D_UNLINK,
    S_D_SEL,
    S_W_CHK,
    S_W_RD,
    S_W_CMP,
    S_D_RDL,
    S_D_MOVE,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd.op     = DP_NOP;
    cmd.resp   = 1'b0;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.op == OP_INSERT) begin
          if (st.full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            cmd.op    = DP_WR_VAL_NEW;
            state_nxt = S_I_CHK;
          end
        end else if (st.op == OP_DELETE || st.op == OP_FIND) begin
          state_nxt = S_L_CHK;
        end else begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end
      end
      S_I_CHK: state_nxt = st.cur_end ? S_I_LINK : S_I_RD;
      S_I_RD:  state_nxt = S_I_CMP;
      S_I_CMP: begin
        if (st.below) begin
          cmd.op    = DP_STEP;
          state_nxt = S_I_CHK;
        end else begin
          state_nxt = S_I_LINK;
        end
      end
      S_I_LINK: begin
        cmd.op    = DP_WR_LINK_NEW;
        state_nxt = S_I_PRED;
      end
      S_I_PRED: begin
        cmd.op     = DP_LINK_PRED_NEW;
        status_nxt = ST_DONE;
        state_nxt  = S_RESP;
      end
      S_L_CHK: begin
        if (st.cur_end) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_L_RD;
        end
      end
      S_L_RD: state_nxt = S_L_CMP;
      S_L_CMP: begin
        if (st.equal) begin
          cmd.op = DP_MARK_LOC;
          if (st.op == OP_FIND) begin
            status_nxt = ST_DONE;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_D_UNLINK;
          end
        end else begin
          cmd.op    = DP_STEP;
          state_nxt = S_L_CHK;
        end
      end
      S_D_UNLINK: begin
        cmd.op    = DP_UNLINK;
        state_nxt = S_D_SEL;
      end
      S_D_SEL: begin
        if (st.loc_is_last) begin
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
        end else if (st.head_is_last) begin
          cmd.op    = DP_HEAD_LOC;
          state_nxt = S_D_RDL;
        end else begin
          cmd.op    = DP_WALK_START;
          state_nxt = S_W_CHK;
        end
      end
      S_W_CHK: state_nxt = st.cur_end ? S_D_RDL : S_W_RD;
      S_W_RD:  state_nxt = S_W_CMP;
      S_W_CMP: begin
        if (st.link_hit) begin
          cmd.op    = DP_FIX_LINK;
          state_nxt = S_D_RDL;
        end else begin
          cmd.op    = DP_STEP;
          state_nxt = S_W_CHK;
        end
      end
      S_D_RDL: begin
        cmd.op    = DP_RD_LAST;
        state_nxt = S_D_MOVE;
      end
      S_D_MOVE: begin
        cmd.op     = DP_MOVE;
        status_nxt = ST_DONE;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

`ifndef NO_ASSERTIONS
  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp |-> st.out_free)
    else $error("result issued into occupied output register");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while one is in work");

  a_idle_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp |=> in_tready)
    else $error("controller not idle after result");
`endif

endmodule

FILE: rtl/sorted_linked_list_table.sv
// sorted_linked_list_table: ascending list of signed 32-bit keys kept as a
// linked list in a 16-slot table (value memory, link memory, head, count).
// input channel: in_tuser carries the operation (insert, delete, find),
// in_tdata the key; one transfer starts one operation.
// output channel: exactly one result transfer per operation; out_tuser is
// the status (done, not found, full), out_tdata the slot and the count.
// walk: every walk step passes the check, memory read and compare states,
// set by the registered read of the single-read-port link and value memories.
//   insert: write the key into the top slot, walk past the smaller keys, then
//           link the new slot in   find: walk until the key matches or the list ends
//   delete: find walk, unlink, then a predecessor walk for the top slot (skipped
//           if the top slot is the deleted slot or the head) and the move of the
//           top slot into the freed one (skipped if the deleted slot is the top)
// one operation is in work at a time; the next input transfer can be taken
// from the cycle in which the result first sits in the output register.
// reset (synchronous, active low) empties the list at once: head = none,
// count = 0; no clearing pass, slots above the count are never read.
// when the receiver stalls, the result waits in the output register and a
// following operation finishes its walk and then holds until it drains.
module sorted_linked_list_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sll_pkg::KEY_W-1:0]      in_tdata,   // [31:0] key_value
  input  logic [sll_pkg::OP_W-1:0]       in_tuser,   // [1:0] operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sll_pkg::OUT_DATA_W-1:0] out_tdata,  // [4:0] slot_index, [9:5] count_after
  output logic [sll_pkg::ST_W-1:0]       out_tuser   // [1:0] status
);
  import sll_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t st;

  // sequencer: walks, insert linking, unlink and compaction steps
  sll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: memories, pointers, count and output register
  sll_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
